FILE: hdl/rv32im_alu_pkg.sv
// ----------------------------------------------------------------------------
// RV32IM ALU package
// Operation classes, decoded item type and shared constants.
// ----------------------------------------------------------------------------
package rv32im_alu_pkg;

    localparam int XLEN = 32;
    localparam logic [6:0] F7_BASE = 7'd0;
    localparam logic [6:0] F7_ALT  = 7'd32;
    localparam logic [6:0] F7_MULDIV = 7'd1;
    localparam logic [4:0] SHAMT_MASK = 5'b11111;

    typedef enum logic [4:0] {
        OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA,
        OP_OR, OP_AND, OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU,
        OP_DIV, OP_DIVU, OP_REM, OP_REMU, OP_BAD
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [XLEN-1:0]  a;
        logic [XLEN-1:0]  b;
    } t_item;

endpackage

FILE: hdl/rv32im_alu_front.sv
// ----------------------------------------------------------------------------
// RV32IM ALU front end
// Classify the instruction, pick the second operand and queue the item.
// ----------------------------------------------------------------------------
module rv32im_alu_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [2:0]                  i_func,
    input  logic [6:0]                  i_variant,
    input  logic                        i_use_immediate,
    input  logic [31:0]                 i_operand_a,
    input  logic [31:0]                 i_operand_b,
    input  logic [11:0]                 i_immediate,
    output logic                        o_valid,
    input  logic                        i_take,
    output rv32im_alu_pkg::t_item       o_item
);
    import rv32im_alu_pkg::*;

    localparam int DEPTH = 4;
    t_item          r_mem [DEPTH];
    logic [1:0]     r_wp, r_rp;
    logic [2:0]     r_cnt;
    t_item          n_item;
    logic           w_push, w_take;

    always_comb begin
        n_item.a  = i_operand_a;
        n_item.b  = i_use_immediate ? {{20{i_immediate[11]}}, i_immediate} : i_operand_b;
        n_item.op = OP_BAD;
        if (i_use_immediate) begin
            case (i_func)
                3'd0: n_item.op = OP_ADD;
                3'd1: n_item.op = OP_SLL;
                3'd2: n_item.op = OP_SLT;
                3'd3: n_item.op = OP_SLTU;
                3'd4: n_item.op = OP_XOR;
                3'd5: n_item.op = (i_variant == F7_BASE) ? OP_SRL :
                                  (i_variant == F7_ALT) ? OP_SRA : OP_BAD;
                3'd6: n_item.op = OP_OR;
                default: n_item.op = OP_AND;
            endcase
        end else if (i_variant == F7_BASE) begin
            case (i_func)
                3'd0: n_item.op = OP_ADD;
                3'd1: n_item.op = OP_SLL;
                3'd2: n_item.op = OP_SLT;
                3'd3: n_item.op = OP_SLTU;
                3'd4: n_item.op = OP_XOR;
                3'd5: n_item.op = OP_SRL;
                3'd6: n_item.op = OP_OR;
                default: n_item.op = OP_AND;
            endcase
        end else if (i_variant == F7_ALT) begin
            case (i_func)
                3'd0: n_item.op = OP_SUB;
                3'd5: n_item.op = OP_SRA;
                default: n_item.op = OP_BAD;
            endcase
        end else if (i_variant == F7_MULDIV) begin
            case (i_func)
                3'd0: n_item.op = OP_MUL;
                3'd1: n_item.op = OP_MULH;
                3'd2: n_item.op = OP_MULHSU;
                3'd3: n_item.op = OP_MULHU;
                3'd4: n_item.op = OP_DIV;
                3'd5: n_item.op = OP_DIVU;
                3'd6: n_item.op = OP_REM;
                default: n_item.op = OP_REMU;
            endcase
        end
    end

    assign o_full  = (r_cnt == 3'(DEPTH));
    assign o_valid = (r_cnt != 3'd0);
    assign w_push  = i_push && !o_full;
    assign w_take  = i_take && o_valid;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= n_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (w_take) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(w_push) - 3'(w_take);
        end
    end

endmodule

FILE: hdl/rv32im_alu_div.sv
// ----------------------------------------------------------------------------
// RV32IM ALU divider
// Pipelined restoring divider, one quotient bit per stage, 32 stages.
// ----------------------------------------------------------------------------
module rv32im_alu_div (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [31:0]          i_n,
    input  logic [31:0]          i_d,
    output logic [31:0]          o_q,
    output logic [31:0]          o_r
);
    import rv32im_alu_pkg::*;

    logic [31:0] r_q [33];
    logic [31:0] r_r [33];
    logic [31:0] r_d [33];

    always_comb begin
        r_q[0] = i_n;
        r_r[0] = '0;
        r_d[0] = i_d;
    end

    for (genvar s = 0; s < 32; s++) begin : g_stage
        logic [32:0] w_t;
        logic [32:0] w_s;
        assign w_t = {r_r[s], r_q[s][31]};
        assign w_s = w_t - {1'b0, r_d[s]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[s+1] <= r_d[s];
                r_q[s+1] <= {r_q[s][30:0], !w_s[32]};
                r_r[s+1] <= w_s[32] ? w_t[31:0] : w_s[31:0];
            end
        end
    end

    assign o_q = r_q[32];
    assign o_r = r_r[32];

endmodule

FILE: hdl/rv32im_alu_back.sv
// ----------------------------------------------------------------------------
// RV32IM ALU back end
// Execute pipeline of fixed length with a 64-entry output queue.
// ----------------------------------------------------------------------------
module rv32im_alu_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_take,
    input  rv32im_alu_pkg::t_item  i_item,
    output logic                   o_empty,
    input  logic                   i_pop,
    output logic [31:0]            o_result,
    output logic                   o_illegal
);
    import rv32im_alu_pkg::*;

    // stage 0 prep, 1 multiply, 2 divider input, 3..34 divide, fix-up on queue write
    localparam int LAT = 35;
    localparam int QD  = 64;
    localparam int CW  = $clog2(QD + 1);
    localparam int PW  = $clog2(QD);

    logic [LAT-1:0]  r_vld;
    logic [CW-1:0]   r_cnt;
    logic            w_adv, w_pop;
    logic [CW-1:0]   r_fly;

    // in-flight credit: accept only if a slot in the queue is guaranteed
    assign w_adv  = i_valid && (r_cnt + r_fly < CW'(QD));
    assign o_take = w_adv;

    // stage 0 registers
    t_op         r0_op;
    logic [31:0] r0_a, r0_b;
    // stage 1: products and absolute values
    t_op         r1_op;
    logic [31:0] r1_a, r1_b, r1_res;
    logic [63:0] r1_pu;
    logic [31:0] w_ma, w_mb;
    logic        w_sgn;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_op <= i_item.op;
            r0_a  <= i_item.a;
            r0_b  <= i_item.b;
        end
        r1_op <= r0_op;
        r1_a  <= r0_a;
        r1_b  <= r0_b;
        r1_pu <= 64'(r0_a) * 64'(r0_b);
    end

    always_comb begin
        w_sgn = (r1_op == OP_DIV) || (r1_op == OP_REM);
        w_ma  = (w_sgn && r1_a[31]) ? -r1_a : r1_a;
        w_mb  = (w_sgn && r1_b[31]) ? -r1_b : r1_b;
    end

    // simple ops and multiply fixups computed at stage 1 output
    always_comb begin
        r1_res = '0;
        case (r1_op)
            OP_ADD:    r1_res = r1_a + r1_b;
            OP_SUB:    r1_res = r1_a - r1_b;
            OP_SLL:    r1_res = r1_a << (r1_b[4:0] & SHAMT_MASK);
            OP_SLT:    r1_res = 32'($signed(r1_a) < $signed(r1_b));
            OP_SLTU:   r1_res = 32'(r1_a < r1_b);
            OP_XOR:    r1_res = r1_a ^ r1_b;
            OP_SRL:    r1_res = r1_a >> r1_b[4:0];
            OP_SRA:    r1_res = 32'($signed(r1_a) >>> r1_b[4:0]);
            OP_OR:     r1_res = r1_a | r1_b;
            OP_AND:    r1_res = r1_a & r1_b;
            OP_MUL:    r1_res = r1_pu[31:0];
            OP_MULH:   r1_res = r1_pu[63:32] - (r1_a[31] ? r1_b : '0)
                                - (r1_b[31] ? r1_a : '0);
            OP_MULHSU: r1_res = r1_pu[63:32] - (r1_a[31] ? r1_b : '0);
            OP_MULHU:  r1_res = r1_pu[63:32];
            default:   r1_res = '0;
        endcase
    end

    // side band carried alongside the divider
    localparam int DL = 32;
    t_op         r_sop [DL+1];
    logic [31:0] r_sa  [DL+1];
    logic [31:0] r_sb  [DL+1];
    logic [31:0] r_sr  [DL+1];
    logic [31:0] w_q, w_r;

    always_ff @(posedge i_clk) begin
        r_sop[0] <= r1_op;
        r_sa[0]  <= r1_a;
        r_sb[0]  <= r1_b;
        r_sr[0]  <= r1_res;
        for (int k = 0; k < DL; k++) begin
            r_sop[k+1] <= r_sop[k];
            r_sa[k+1]  <= r_sa[k];
            r_sb[k+1]  <= r_sb[k];
            r_sr[k+1]  <= r_sr[k];
        end
    end

    logic [31:0] r_dn, r_dd;
    always_ff @(posedge i_clk) begin
        r_dn <= w_ma;
        r_dd <= w_mb;
    end

    // divider input registered at side band stage 0
    rv32im_alu_div u_div (
        .i_clk (i_clk),
        .i_en  (1'b1),
        .i_n   (r_dn),
        .i_d   (r_dd),
        .o_q   (w_q),
        .o_r   (w_r)
    );

    // finish: signs and special cases, applied on the way into the queue
    t_op         w_fop;
    logic [31:0] w_fa, w_fb, w_res;
    logic        w_bz, w_ovf;
    assign w_fop = r_sop[DL];
    assign w_fa  = r_sa[DL];
    assign w_fb  = r_sb[DL];
    assign w_bz  = (w_fb == '0);
    assign w_ovf = (w_fa == 32'h8000_0000) && (w_fb == '1);

    always_comb begin
        case (w_fop)
            OP_DIV:  w_res = w_bz ? '1 : w_ovf ? w_fa :
                             ((w_fa[31] ^ w_fb[31]) ? -w_q : w_q);
            OP_DIVU: w_res = w_bz ? '1 : w_q;
            OP_REM:  w_res = w_bz ? w_fa : w_ovf ? '0 : (w_fa[31] ? -w_r : w_r);
            OP_REMU: w_res = w_bz ? w_fa : w_r;
            default: w_res = r_sr[DL];
        endcase
    end

    // result queue
    logic [32:0]  r_mem [QD];
    logic [PW-1:0] r_wp, r_rp;
    logic [32:0]  r_out;
    logic         r_ov;

    // stages: r_vld[0]=r0, [1]=r1, [2]=side0 ... [34]=side32
    assign w_pop   = i_pop && !o_empty;
    assign o_empty = !r_ov;
    assign o_result = r_out[31:0];
    assign o_illegal = r_out[32];

    logic [CW-1:0] w_qn;
    logic          w_rd;
    assign w_qn = r_cnt;
    assign w_rd = (!r_ov || w_pop) && (w_qn != '0);

    always_ff @(posedge i_clk) begin
        if (r_vld[LAT-1]) r_mem[r_wp] <= {w_fop == OP_BAD, w_res};
        if (w_rd) r_out <= r_mem[r_rp];
        if (!i_rst_n) begin
            r_vld <= '0;
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_fly <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_adv};
            if (r_vld[LAT-1]) r_wp <= r_wp + PW'(1);
            if (w_rd) r_rp <= r_rp + PW'(1);
            r_cnt <= r_cnt + CW'(r_vld[LAT-1]) - CW'(w_rd);
            r_fly <= r_fly + CW'(w_adv) - CW'(r_vld[LAT-1]);
            if (w_rd) r_ov <= 1'b1;
            else if (w_pop) r_ov <= 1'b0;
        end
    end

endmodule

FILE: hdl/rv32im_integer_alu_top.sv
// ----------------------------------------------------------------------------
// RV32IM integer ALU
// OP and OP-IMM execute unit for the base integer set and the M extension.
// ----------------------------------------------------------------------------
// The unit takes one item per cycle while full is low and returns one result
// item per input item, in order. A front queue of four entries decodes each
// item into an operation class; the back end is a fixed 35-stage pipeline (a
// register stage, a 32x32 multiply, a divider input register, a 32-stage
// restoring divider with one quotient bit per stage, and a sign fix-up on the
// way into the queue) feeding a 64-entry result queue. When nothing is waiting,
// empty drops once the result is written to the queue and loaded into the
// output register; the sustained rate is one item per cycle while results are
// popped. Unhandled encodings return illegal high with a zero result.
module rv32im_integer_alu_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_func,
    input  logic [6:0]  i_variant,
    input  logic        i_use_immediate,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    input  logic [11:0] i_immediate,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_result,
    output logic        o_illegal
);
    import rv32im_alu_pkg::*;

    t_item w_item;
    logic  w_valid, w_take;

    // decode and hold items until the execute pipeline has room
    rv32im_alu_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_func          (i_func),
        .i_variant       (i_variant),
        .i_use_immediate (i_use_immediate),
        .i_operand_a     (i_operand_a),
        .i_operand_b     (i_operand_b),
        .i_immediate     (i_immediate),
        .o_valid         (w_valid),
        .i_take          (w_take),
        .o_item          (w_item)
    );

    // execute and queue results
    rv32im_alu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_valid),
        .o_take    (w_take),
        .i_item    (w_item),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (o_result),
        .o_illegal (o_illegal)
    );

    // an illegal item always carries a zero result
    a_illegal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_illegal) |-> (o_result == '0))
        else $error("illegal item with non-zero result");

    // the back end never takes an item while the front queue is empty
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_valid)
        else $error("back end took from empty front queue");

endmodule
